>>> hw/rtl/jsse_pkg.sv
package jsse_pkg;

  // Item modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_TASK  = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  localparam int IN_BYTES  = 7;
  localparam int OUT_BYTES = 18;

  // Input item, first field in the lowest bits (packed structs fill from the MSB)
  typedef struct packed {
    logic [4:0]  pad;
    logic [23:0] due_date;
    logic [15:0] duration;
    logic [3:0]  machine_index;
    logic [4:0]  job_index;
    logic [1:0]  mode;
  } in_item_t;

  // Result item, first field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic        overflow;
    logic [31:0] objective_value;
    logic [31:0] running_tardiness;
    logic [23:0] running_makespan;
    logic [23:0] job_tardiness;
    logic [23:0] completion_time;
  } result_t;

endpackage

>>> hw/rtl/job_shop_schedule_evaluator.sv
// Job-shop schedule evaluator. Each input item is a clear, a task or a job
// close, and each gives exactly one result item. A task starts at the later of
// its machine's and its job's ready time and finishes after its duration;
// that finish becomes both ready times. A close reports the job's finish, its
// lateness against the due date, and updates the running makespan and total
// tardiness; objective_value shows one of the two per cfg_data. Times stick at
// 2^TIME_BITS-1 and the tardiness total at 2^32-1, raising overflow until the
// next clear. Throughput is one item per clock while results are taken: an
// item sits in the input register while the ready tables (flip-flops, one
// read port each) and the max/add/compare path settle, then lands in the
// output register when that is free, and out_tvalid rises with it. A full
// output register that is not taken holds the input register, which then
// holds in_tready low. Ready tables and totals are in flip-flops and are
// zeroed at once by reset or a clear item.
module job_shop_schedule_evaluator #(
  parameter int NUM_JOBS     = 32,
  parameter int NUM_MACHINES = 16,
  parameter int TIME_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mode[1:0], job_index[6:2], machine_index[10:7], duration[26:11],
  // due_date[50:27], zero fill[55:51]
  input  logic [jsse_pkg::IN_BYTES*8-1:0]     in_tdata,
  // Result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // completion_time[23:0], job_tardiness[47:24], running_makespan[71:48],
  // running_tardiness[103:72], objective_value[135:104], overflow[136],
  // zero fill[143:137]
  output logic [jsse_pkg::OUT_BYTES*8-1:0]    out_tdata,
  // Objective select register (0 makespan, 1 total tardiness)
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data
);

  logic               s1_vld_r;
  jsse_pkg::in_item_t s1_item_r;
  logic               out_vld_r;
  jsse_pkg::result_t  out_data_r;
  logic               obj_sel_r;
  logic               advance;
  logic               fire;
  jsse_pkg::result_t  res;

  // The output register frees when empty or when taken this cycle
  assign advance   = !out_vld_r || out_tready;
  assign fire      = s1_vld_r && advance;
  assign in_tready = !s1_vld_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_sel_r <= 1'b0;
    end else if (cfg_valid) begin
      obj_sel_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= jsse_pkg::in_item_t'(in_tdata);
    end
  end

  jsse_core #(
    .NUM_JOBS     (NUM_JOBS),
    .NUM_MACHINES (NUM_MACHINES),
    .TIME_BITS    (TIME_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .item             (s1_item_r),
    .objective_select (obj_sel_r),
    .res              (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

endmodule

>>> hw/rtl/jsse_core.sv
module jsse_core #(
  parameter int NUM_JOBS     = 32,
  parameter int NUM_MACHINES = 16,
  parameter int TIME_BITS    = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  jsse_pkg::in_item_t item,
  input  logic               objective_select,
  output jsse_pkg::result_t  res
);

  localparam int JW  = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
  localparam int MW  = (NUM_MACHINES > 1) ? $clog2(NUM_MACHINES) : 1;
  localparam int JXW = (JW > 5) ? JW : 5;
  localparam int MXW = (MW > 4) ? MW : 4;
  localparam int SW  = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
  localparam int CW  = (TIME_BITS > 24) ? TIME_BITS : 24;
  localparam int AW  = ((CW > 32) ? CW : 32) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [TIME_BITS-1:0] mach_rdy_r [NUM_MACHINES];
  logic [TIME_BITS-1:0] job_rdy_r  [NUM_JOBS];
  logic [TIME_BITS-1:0] mk_acc_r, mk_acc_nxt;
  logic [31:0]          tard_acc_r, tard_acc_nxt;
  logic                 ovf_r, ovf_nxt;

  logic [JXW-1:0]       job_x;
  logic [MXW-1:0]       mach_x;
  logic [JW-1:0]        j_sel;
  logic [MW-1:0]        m_sel;
  logic                 job_ok, mach_ok, task_wr;
  logic [TIME_BITS-1:0] mach_rd, job_rd, start;
  logic [SW-1:0]        task_sum;
  logic                 task_sat;
  logic [TIME_BITS-1:0] task_comp;
  logic [CW-1:0]        cl_comp_c, due_c, cl_tard;
  logic [AW-1:0]        tard_sum;
  logic                 tard_sat;
  logic [TIME_BITS-1:0] comp_out;
  logic [CW-1:0]        tard_out;

  // Index range checks in a width that holds the table depth itself
  assign job_x   = JXW'(item.job_index);
  assign mach_x  = MXW'(item.machine_index);
  assign j_sel   = job_x[JW-1:0];
  assign m_sel   = mach_x[MW-1:0];
  assign job_ok  = {1'b0, job_x} < (JXW + 1)'(NUM_JOBS);
  assign mach_ok = {1'b0, mach_x} < (MXW + 1)'(NUM_MACHINES);

  assign mach_rd = mach_rdy_r[m_sel];
  assign job_rd  = job_rdy_r[j_sel];

  // Task: start at the later ready time, saturate the finish time
  assign start     = (mach_rd > job_rd) ? mach_rd : job_rd;
  assign task_sum  = SW'(start) + SW'(item.duration);
  assign task_sat  = (task_sum >> TIME_BITS) != '0;
  assign task_comp = task_sat ? TIME_MAX : task_sum[TIME_BITS-1:0];

  // Close: lateness against the due date, saturating total
  assign cl_comp_c = CW'(job_rd);
  assign due_c     = CW'(item.due_date);
  assign cl_tard   = (cl_comp_c > due_c) ? (cl_comp_c - due_c) : '0;
  assign tard_sum  = AW'(tard_acc_r) + AW'(cl_tard);
  assign tard_sat  = tard_sum[AW-1:32] != '0;

  assign task_wr = fire && (item.mode == jsse_pkg::MODE_TASK) && job_ok && mach_ok;

  always_comb begin
    mk_acc_nxt   = mk_acc_r;
    tard_acc_nxt = tard_acc_r;
    ovf_nxt      = ovf_r;
    comp_out     = '0;
    tard_out     = '0;
    case (item.mode)
      jsse_pkg::MODE_CLEAR: begin
        mk_acc_nxt   = '0;
        tard_acc_nxt = '0;
        ovf_nxt      = 1'b0;
      end
      jsse_pkg::MODE_TASK: begin
        if (job_ok && mach_ok) begin
          comp_out = task_comp;
          ovf_nxt  = ovf_r | task_sat;
        end
      end
      jsse_pkg::MODE_CLOSE: begin
        if (job_ok) begin
          comp_out     = job_rd;
          tard_out     = cl_tard;
          mk_acc_nxt   = (job_rd > mk_acc_r) ? job_rd : mk_acc_r;
          tard_acc_nxt = tard_sat ? 32'hFFFF_FFFF : tard_sum[31:0];
          ovf_nxt      = ovf_r | tard_sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res                   = '0;
    res.completion_time   = 24'(comp_out);
    res.job_tardiness     = 24'(tard_out);
    res.running_makespan  = 24'(mk_acc_nxt);
    res.running_tardiness = tard_acc_nxt;
    res.objective_value   = objective_select ? tard_acc_nxt : 32'(mk_acc_nxt);
    res.overflow          = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.mode == jsse_pkg::MODE_CLEAR)) begin
      for (int i = 0; i < NUM_MACHINES; i++) mach_rdy_r[i] <= '0;
      for (int i = 0; i < NUM_JOBS; i++) job_rdy_r[i] <= '0;
    end else if (task_wr) begin
      mach_rdy_r[m_sel] <= task_comp;
      job_rdy_r[j_sel]  <= task_comp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mk_acc_r   <= '0;
      tard_acc_r <= '0;
      ovf_r      <= 1'b0;
    end else if (fire) begin
      mk_acc_r   <= mk_acc_nxt;
      tard_acc_r <= tard_acc_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.mode == jsse_pkg::MODE_CLEAR)
    |=> (mk_acc_r == '0 && tard_acc_r == '0 && !ovf_r))
    else $error("totals not zero after clear");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && !(fire && item.mode == jsse_pkg::MODE_CLEAR)) |=> ovf_r)
    else $error("overflow dropped without clear");

  a_tard_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.mode != jsse_pkg::MODE_CLEAR) |=> (tard_acc_r >= $past(tard_acc_r)))
    else $error("total tardiness decreased");

  a_mk_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.mode != jsse_pkg::MODE_CLEAR) |=> (mk_acc_r >= $past(mk_acc_r)))
    else $error("makespan decreased");

endmodule
